/* design/spfa_pkg.sv */
// Shared constants for the swap pool frame allocator.
// Depends on nothing; imported by every module and interface of the block.
package spfa_pkg;

    localparam int POOL_FRAMES = 16;
    localparam int PAGE_SHIFT  = 12;
    localparam int PAGE_BYTES  = 1 << PAGE_SHIFT;
    localparam int FRAME_W     = $clog2(POOL_FRAMES);

    localparam int CODE_W  = 5;
    localparam int ASID_W  = 4;
    localparam int PAGE_W  = 20;
    localparam int INDEX_W = 4;
    localparam int ADDR_W  = 32;

    localparam logic [CODE_W-1:0] CAUSE_TLB_LOAD  = 5'd25;
    localparam logic [CODE_W-1:0] CAUSE_TLB_STORE = 5'd26;

    localparam logic [FRAME_W-1:0] FRAME_LAST  = FRAME_W'(POOL_FRAMES - 1);
    localparam logic [FRAME_W-1:0] FULL_VICTIM = FRAME_W'(1 % POOL_FRAMES);

    localparam logic [ASID_W-1:0] OWNER_FREE = '0;

endpackage

/* design/spfa_if.sv */
// Handshake channels of the swap pool frame allocator: fault words in, result words out.
// Depends on spfa_pkg.
interface spfa_fault_if
    import spfa_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] exc_code;
    logic [ASID_W-1:0] asid;
    logic [PAGE_W-1:0] page_number;

    modport source (output valid, output exc_code, output asid, output page_number,
                    input ready);
    modport sink   (input valid, input exc_code, input asid, input page_number,
                    output ready);
endinterface

interface spfa_result_if
    import spfa_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               trap;
    logic               hit;
    logic [INDEX_W-1:0] frame_index;
    logic [ADDR_W-1:0]  frame_address;
    logic               writeback;
    logic [ASID_W-1:0]  victim_asid;
    logic [PAGE_W-1:0]  evict_page;

    modport source (output valid, output trap, output hit, output frame_index,
                    output frame_address, output writeback, output victim_asid,
                    output evict_page, input ready);
    modport sink   (input valid, input trap, input hit, input frame_index,
                    input frame_address, input writeback, input victim_asid,
                    input evict_page, output ready);
endinterface

/* design/swap_pool_frame_allocator_core.sv */
// Top level of the swap pool frame allocator: frame tables, scan sequencer, result register.
// Depends on spfa_pkg and the channel interfaces in spfa_if.sv.
//
// channel   dir  handshake          payload
// fault     in   valid/ready        exc_code, asid, page_number
// result    out  valid/ready        trap, hit, frame_index, frame_address, writeback,
//                                   victim_asid, evict_page
// cfg       in   cfg_wr_en          cfg_wr_data (pool base address)
//
// One fault word is taken at a time; fault.ready is high only while the sequencer is idle.
// A trap skips both scans; a serviced fault runs one owner/page compare per cycle over the
// hit scan, which stops on a match, and then, on a miss, over the free scan.
// The result register holds its word until taken; a stall there holds the sequencer.
// Reset clears all frame owners to free and the scan start to frame 0 at once.
module swap_pool_frame_allocator_core
    import spfa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [ADDR_W-1:0] cfg_wr_data,
    spfa_fault_if.sink        fault,
    spfa_result_if.source     result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HIT  = 3'd1;
    localparam logic [2:0] S_FREE = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;

    logic [2:0]         state_reg, state_next;
    logic [FRAME_W-1:0] cnt_reg, cnt_next;
    logic [FRAME_W-1:0] start_reg, start_next;
    logic [ADDR_W-1:0]  base_reg, base_next;

    logic [ASID_W-1:0]  owner_reg [POOL_FRAMES];
    logic [PAGE_W-1:0]  page_reg  [POOL_FRAMES];

    logic [ASID_W-1:0]  asid_reg, asid_next;
    logic [PAGE_W-1:0]  pnum_reg, pnum_next;
    logic               trap_reg, trap_next;
    logic               hit_reg, hit_next;
    logic               wb_reg, wb_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [ASID_W-1:0]  vasid_reg, vasid_next;
    logic [PAGE_W-1:0]  vpage_reg, vpage_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_trap_reg, out_hit_reg, out_wb_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [ASID_W-1:0]  out_vasid_reg;
    logic [PAGE_W-1:0]  out_vpage_reg;
    logic               out_load;

    logic               install_en;
    logic [FRAME_W-1:0] install_idx;
    logic [FRAME_W:0]   free_sum;
    logic [FRAME_W-1:0] free_idx;
    logic               accept;
    logic               serviced;
    logic [ADDR_W-1:0]  frame_offset;

    assign accept      = fault.valid && fault.ready;
    assign fault.ready = (state_reg == S_IDLE);
    assign serviced    = fault.exc_code inside {CAUSE_TLB_LOAD, CAUSE_TLB_STORE};

    assign free_sum = {1'b0, start_reg} + {1'b0, cnt_reg};
    assign free_idx = (free_sum >= (FRAME_W + 1)'(POOL_FRAMES))
                    ? FRAME_W'(free_sum - (FRAME_W + 1)'(POOL_FRAMES))
                    : FRAME_W'(free_sum);

    assign frame_offset = ADDR_W'(frame_reg) << PAGE_SHIFT;
    assign out_load     = (state_reg == S_FIN) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        start_next  = start_reg;
        base_next   = cfg_wr_en ? cfg_wr_data : base_reg;
        asid_next   = asid_reg;
        pnum_next   = pnum_reg;
        trap_next   = trap_reg;
        hit_next    = hit_reg;
        wb_next     = wb_reg;
        frame_next  = frame_reg;
        vasid_next  = vasid_reg;
        vpage_next  = vpage_reg;
        install_en  = 1'b0;
        install_idx = free_idx;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    asid_next  = fault.asid;
                    pnum_next  = fault.page_number;
                    trap_next  = !serviced;
                    hit_next   = 1'b0;
                    wb_next    = 1'b0;
                    frame_next = '0;
                    vasid_next = '0;
                    vpage_next = '0;
                    cnt_next   = '0;
                    state_next = serviced ? S_HIT : S_FIN;
                end
            end
            S_HIT:
            begin
                if (owner_reg[cnt_reg] != OWNER_FREE && owner_reg[cnt_reg] == asid_reg
                    && page_reg[cnt_reg] == pnum_reg)
                begin
                    hit_next   = 1'b1;
                    frame_next = cnt_reg;
                    state_next = S_FIN;
                end
                else if (cnt_reg == FRAME_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_FREE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FREE:
            begin
                if (owner_reg[free_idx] == OWNER_FREE)
                begin
                    frame_next  = free_idx;
                    start_next  = free_idx;
                    install_en  = 1'b1;
                    install_idx = free_idx;
                    state_next  = S_FIN;
                end
                else if (cnt_reg == FRAME_LAST)
                begin
                    frame_next  = FULL_VICTIM;
                    wb_next     = 1'b1;
                    vasid_next  = owner_reg[FULL_VICTIM];
                    vpage_next  = page_reg[FULL_VICTIM];
                    install_en  = 1'b1;
                    install_idx = FULL_VICTIM;
                    state_next  = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            start_reg     <= '0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < POOL_FRAMES; k++)
            begin
                owner_reg[k] <= OWNER_FREE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            start_reg     <= start_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
            if (install_en)
            begin
                owner_reg[install_idx] <= asid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        asid_reg  <= asid_next;
        pnum_reg  <= pnum_next;
        trap_reg  <= trap_next;
        hit_reg   <= hit_next;
        wb_reg    <= wb_next;
        frame_reg <= frame_next;
        vasid_reg <= vasid_next;
        vpage_reg <= vpage_next;
        if (install_en)
        begin
            page_reg[install_idx] <= pnum_reg;
        end
        if (out_load)
        begin
            out_trap_reg  <= trap_reg;
            out_hit_reg   <= hit_reg;
            out_wb_reg    <= wb_reg;
            out_index_reg <= INDEX_W'(frame_reg);
            out_addr_reg  <= trap_reg ? '0 : base_reg + frame_offset;
            out_vasid_reg <= vasid_reg;
            out_vpage_reg <= vpage_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.trap          = out_trap_reg;
    assign result.hit           = out_hit_reg;
    assign result.frame_index   = out_index_reg;
    assign result.frame_address = out_addr_reg;
    assign result.writeback     = out_wb_reg;
    assign result.victim_asid   = out_vasid_reg;
    assign result.evict_page    = out_vpage_reg;

    a_trap_skips_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && fault.exc_code != CAUSE_TLB_LOAD && fault.exc_code != CAUSE_TLB_STORE)
        |=> (state_reg == S_FIN) && trap_reg)
        else $error("trap fault entered a scan");

    a_trap_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.trap)
        |-> (!result.hit && !result.writeback && result.frame_address == '0))
        else $error("trap result carries frame data");

    a_wb_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.writeback)
        |-> (!result.hit && result.frame_index == INDEX_W'(FULL_VICTIM)))
        else $error("writeback not on the fixed victim frame");

    a_start_moves_on_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start_reg != $past(start_reg)) |-> ($past(state_reg) == S_FREE))
        else $error("scan start moved outside the free scan");

    a_install_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        install_en |-> (state_reg == S_FREE) && !trap_reg && !hit_reg)
        else $error("frame installed outside the free scan");

endmodule

/* tb/sv/swap_pool_frame_allocator_core_tb.sv */
// Testbench for swap_pool_frame_allocator_core: drives fault words, predicts and checks
// every result word against a frame-pool predictor held in a small scoreboard class.
// Depends on spfa_pkg, spfa_if.sv and the allocator core.
module swap_pool_frame_allocator_core_tb
    import spfa_pkg::*;
;

    localparam int LONG_HOLD   = 400;
    localparam int IDLE_LIMIT  = 3000;
    localparam int DRAIN       = 2 * POOL_FRAMES + 2;
    localparam int PHASES      = 5;
    localparam int PHASE_WORDS = 115;

    typedef struct packed {
        logic [CODE_W-1:0] exc_code;
        logic [ASID_W-1:0] asid;
        logic [PAGE_W-1:0] page_number;
    } fault_word_t;

    typedef struct packed {
        logic               trap;
        logic               hit;
        logic [INDEX_W-1:0] frame_index;
        logic [ADDR_W-1:0]  frame_address;
        logic               writeback;
        logic [ASID_W-1:0]  victim_asid;
        logic [PAGE_W-1:0]  evict_page;
    } result_word_t;

    class frame_pool_sb;
        logic [ASID_W-1:0] owner [POOL_FRAMES];
        logic [PAGE_W-1:0] page_tag [POOL_FRAMES];
        int unsigned       scan_start;
        logic [ADDR_W-1:0] base;
        result_word_t      awaited [$];
        int                errors;
        int                shown;
        int                words;
        int                traps;
        int                hits;
        int                fills;
        int                evictions;

        function new();
            foreach (owner[k])
            begin
                owner[k]    = OWNER_FREE;
                page_tag[k] = '0;
            end
            scan_start = 0;
            base       = '0;
            errors     = 0;
            shown      = 0;
            words      = 0;
            traps      = 0;
            hits       = 0;
            fills      = 0;
            evictions  = 0;
        endfunction

        function void set_base(logic [ADDR_W-1:0] value);
            base = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_fault(fault_word_t f);
            result_word_t r;
            int unsigned  frame;
            int unsigned  idx;
            bit           found;
            r     = '0;
            frame = 0;
            found = 1'b0;
            words++;
            if (f.exc_code != CAUSE_TLB_LOAD && f.exc_code != CAUSE_TLB_STORE)
            begin
                r.trap = 1'b1;
                traps++;
                awaited.push_back(r);
                return;
            end
            for (int k = 0; k < POOL_FRAMES; k++)
            begin
                if (!found && owner[k] != OWNER_FREE && owner[k] == f.asid
                    && page_tag[k] == f.page_number)
                begin
                    frame = k;
                    found = 1'b1;
                end
            end
            if (found)
            begin
                r.hit = 1'b1;
                hits++;
            end
            else
            begin
                for (int k = 0; k < POOL_FRAMES; k++)
                begin
                    idx = (scan_start + k) % POOL_FRAMES;
                    if (!found && owner[idx] == OWNER_FREE)
                    begin
                        frame = idx;
                        found = 1'b1;
                    end
                end
                if (found)
                begin
                    scan_start = frame;
                    fills++;
                end
                else
                begin
                    frame         = FULL_VICTIM;
                    r.writeback   = 1'b1;
                    r.victim_asid = owner[frame];
                    r.evict_page  = page_tag[frame];
                    evictions++;
                end
                owner[frame]    = f.asid;
                page_tag[frame] = f.page_number;
            end
            r.frame_index   = INDEX_W'(frame);
            r.frame_address = base + ADDR_W'(frame * PAGE_BYTES);
            awaited.push_back(r);
        endfunction

        function void check_result(result_word_t a);
            result_word_t e;
            string        bad;
            if (awaited.size() == 0)
            begin
                errors++;
                if (shown < 10)
                begin
                    shown++;
                    $display("unexpected result word: trap=%0d hit=%0d index=%0d address=%h",
                             a.trap, a.hit, a.frame_index, a.frame_address);
                end
                return;
            end
            e   = awaited.pop_front();
            bad = "";
            if (a.trap !== e.trap)                   bad = {bad, " trap"};
            if (a.hit !== e.hit)                     bad = {bad, " hit"};
            if (a.frame_index !== e.frame_index)     bad = {bad, " frame_index"};
            if (a.frame_address !== e.frame_address) bad = {bad, " frame_address"};
            if (a.writeback !== e.writeback)         bad = {bad, " writeback"};
            if (a.victim_asid !== e.victim_asid)     bad = {bad, " victim_asid"};
            if (a.evict_page !== e.evict_page)       bad = {bad, " evict_page"};
            if (bad != "")
            begin
                errors++;
                if (shown < 10)
                begin
                    shown++;
                    $display("result mismatch on%s", bad);
                    $display("  expected trap=%0d hit=%0d idx=%0d addr=%h wb=%0d va=%0d vp=%h",
                             e.trap, e.hit, e.frame_index, e.frame_address, e.writeback,
                             e.victim_asid, e.evict_page);
                    $display("  actual   trap=%0d hit=%0d idx=%0d addr=%h wb=%0d va=%0d vp=%h",
                             a.trap, a.hit, a.frame_index, a.frame_address, a.writeback,
                             a.victim_asid, a.evict_page);
                end
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [ADDR_W-1:0] cfg_wr_data;

    spfa_fault_if  fault_ch ();
    spfa_result_if result_ch ();

    swap_pool_frame_allocator_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fault       (fault_ch),
        .result      (result_ch)
    );

    frame_pool_sb sb;
    bit           no_idle;
    bit           long_hold;
    int           idle_cycles;
    int           base_writes;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // receiver: random stalls, one long hold on request
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (no_idle)
            begin
                result_ch.ready <= 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 99)) inside
                    [0:69]:
                    begin
                        result_ch.ready <= 1'b1;
                    end
                    [70:94]:
                    begin
                        result_ch.ready <= 1'b0;
                        repeat ($urandom_range(1, 3)) @(posedge clk);
                    end
                    default:
                    begin
                        result_ch.ready <= 1'b0;
                        repeat ($urandom_range(10, 40)) @(posedge clk);
                    end
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (fault_ch.valid && fault_ch.ready)
                sb.note_fault({fault_ch.exc_code, fault_ch.asid, fault_ch.page_number});
            if (result_ch.valid && result_ch.ready)
                sb.check_result({result_ch.trap, result_ch.hit, result_ch.frame_index,
                                 result_ch.frame_address, result_ch.writeback,
                                 result_ch.victim_asid, result_ch.evict_page});
            if ((fault_ch.valid && fault_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic fault_word_t mk_fault(logic [CODE_W-1:0] code, logic [ASID_W-1:0] id,
                                             logic [PAGE_W-1:0] pg);
        fault_word_t w;
        w.exc_code    = code;
        w.asid        = id;
        w.page_number = pg;
        return w;
    endfunction

    function automatic fault_word_t random_fault();
        fault_word_t w;
        int          r;
        int          k;
        r             = $urandom_range(0, 99);
        w.exc_code    = ($urandom_range(0, 1) != 0) ? CAUSE_TLB_STORE : CAUSE_TLB_LOAD;
        w.asid        = ASID_W'($urandom_range(1, 8));
        w.page_number = PAGE_W'($urandom);
        if (r < 12)
        begin
            w.exc_code = CODE_W'($urandom_range(0, 31));
            w.asid     = ASID_W'($urandom_range(0, 15));
        end
        else if (r < 55)
        begin
            k = $urandom_range(0, POOL_FRAMES - 1);
            if (sb.owner[k] != OWNER_FREE)
            begin
                w.asid        = sb.owner[k];
                w.page_number = sb.page_tag[k];
            end
        end
        else
        begin
            case ($urandom_range(0, 19))
                0:       w.asid = OWNER_FREE;
                1, 2:    w.asid = ASID_W'($urandom_range(9, 15));
                default: ;
            endcase
            case ($urandom_range(0, 9))
                0:       w.page_number = '1;
                1:       w.page_number = '0;
                2, 3, 4: w.page_number = PAGE_W'($urandom_range(0, 15));
                default: ;
            endcase
        end
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    task automatic send_fault(input fault_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            fault_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        fault_ch.valid       <= 1'b1;
        fault_ch.exc_code    <= w.exc_code;
        fault_ch.asid        <= w.asid;
        fault_ch.page_number <= w.page_number;
        do
            @(posedge clk);
        while (!fault_ch.ready);
    endtask

    task automatic drain_results();
        fault_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_base(input logic [ADDR_W-1:0] value);
        drain_results();
        repeat (DRAIN) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_base(value);
        base_writes++;
    endtask

    initial
    begin
        logic [ADDR_W-1:0] bases [PHASES];
        sb                   = new();
        no_idle              = 1'b0;
        long_hold            = 1'b0;
        idle_cycles          = 0;
        base_writes          = 0;
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_wr_data          = '0;
        fault_ch.valid       = 1'b0;
        fault_ch.exc_code    = '0;
        fault_ch.asid        = '0;
        fault_ch.page_number = '0;
        bases[0] = 32'hFFFF_FFFF;
        bases[1] = $urandom;
        bases[2] = 32'hFFFF_F000;
        bases[3] = $urandom;
        bases[4] = 32'h0000_0000;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_base(32'h0000_0000);

        // traps with extreme fields
        send_fault(mk_fault(CODE_W'(0), ASID_W'(15), '1));
        send_fault(mk_fault(CODE_W'(31), OWNER_FREE, '0));
        send_fault(mk_fault(CAUSE_TLB_LOAD - 1'b1, ASID_W'(1), '0));
        send_fault(mk_fault(CAUSE_TLB_STORE + 1'b1, ASID_W'(8), PAGE_W'(5)));
        // fill, hit, asid zero, high asid
        send_fault(mk_fault(CAUSE_TLB_LOAD, ASID_W'(1), '0));
        send_fault(mk_fault(CAUSE_TLB_LOAD, ASID_W'(1), '0));
        send_fault(mk_fault(CAUSE_TLB_STORE, ASID_W'(8), '1));
        send_fault(mk_fault(CAUSE_TLB_STORE, ASID_W'(15), PAGE_W'(20'h12345)));
        send_fault(mk_fault(CAUSE_TLB_LOAD, OWNER_FREE, PAGE_W'(5)));
        send_fault(mk_fault(CAUSE_TLB_LOAD, OWNER_FREE, PAGE_W'(5)));
        send_fault(mk_fault(CAUSE_TLB_STORE, ASID_W'(1), PAGE_W'(20'h80000)));
        send_fault(mk_fault(CAUSE_TLB_LOAD, ASID_W'(2), '0));
        for (int k = 0; k < 11; k++)
            send_fault(mk_fault(CAUSE_TLB_STORE, ASID_W'(3 + k % 6), PAGE_W'(20'h100 + k)));
        // full pool: evict, free the victim with asid zero, refill by wrap
        send_fault(mk_fault(CAUSE_TLB_LOAD, ASID_W'(4), PAGE_W'(20'hABCDE)));
        send_fault(mk_fault(CAUSE_TLB_LOAD, ASID_W'(8), '1));
        send_fault(mk_fault(CAUSE_TLB_STORE, OWNER_FREE, PAGE_W'(7)));
        send_fault(mk_fault(CAUSE_TLB_STORE, ASID_W'(5), PAGE_W'(9)));
        send_fault(mk_fault(CAUSE_TLB_LOAD, ASID_W'(7), PAGE_W'(20'h10A)));

        for (int p = 0; p < PHASES; p++)
        begin
            write_base(bases[p]);
            no_idle = (p == 2);
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                if (p == 3 && i == 10)
                    long_hold = 1'b1;
                send_fault(random_fault());
                if (i == 60 && p != 2)
                    drain_results();
            end
        end

        drain_results();
        repeat (DRAIN) @(posedge clk);
        $display("covered %0d fault words over %0d base settings: %0d traps, %0d hits",
                 sb.words, base_writes, sb.traps, sb.hits);
        $display("  %0d free-frame fills, %0d writebacks, %0d failed checks",
                 sb.fills, sb.evictions, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
